>>> sv/rbcc_pkg.sv
// Package: shared constants and types of the readout block CRC checker.
`timescale 1ns / 1ps
package rbcc_pkg;

   localparam int WORD_W     = 16;
   localparam int POS_W      = 4;
   localparam int RSP_DATA_W = 72;

   localparam logic [WORD_W-1:0] CRC_POLY = 16'h8408;
   localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;

   // index of the received CRC word within a block
   localparam logic [POS_W-1:0] LAST_POS = 4'd11;
   localparam logic [POS_W-1:0] POS_FIRST  = 4'd0;
   localparam logic [POS_W-1:0] POS_SECOND = 4'd1;
   localparam logic [POS_W-1:0] POS_THIRD  = 4'd2;

   localparam logic [3:0] HDR_NIB_FIRST  = 4'hA;
   localparam logic [3:0] HDR_NIB_SECOND = 4'hC;
   localparam logic [3:0] HDR_NIB_THIRD  = 4'hE;

   typedef struct packed {
      logic             header_ok;
      logic             crc_match;
      logic [15:0]      computed_crc;
      logic [15:0]      received_crc;
      logic [11:0]      chip_id;
      logic [3:0]       status_flags;
      logic [7:0]       event_count;
      logic [11:0]      bunch_count;
   } rsp_type;

endpackage

>>> sv/rbcc_crc_fold.sv
// Module: folds one 16-bit word LSB-first into a reflected CRC-16.
`timescale 1ns / 1ps
module rbcc_crc_fold
   import rbcc_pkg::*;
(
   input  logic [WORD_W-1:0] crc_in,
   input  logic [WORD_W-1:0] word_in,
   output logic [WORD_W-1:0] crc_out
);

   // unrolled bit loop; flattens to a shallow XOR network
   always_comb begin
      logic [WORD_W-1:0] c;
      c = crc_in;
      for (int i = 0; i < WORD_W; i++) begin
         if (c[0] ^ word_in[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

>>> sv/readout_block_crc_checker_core.sv
// Top level: readout block CRC checker core.
`timescale 1ns / 1ps
// Takes a readout block as twelve 16-bit words, one word per accepted req_ handshake: bunch-count,
// event-count and chip-id words, eight channel data words, then the received CRC. The first
// eleven words are folded into a CRC-16/MCRF4XX (poly 0x8408 reflected, init 0xFFFF, no final
// XOR). On the twelfth word one rsp_ word carries the decoded header fields, computed and
// received CRC, a match flag and a header nibble check (A, C, E). req_tuser high marks the first
// word and drops any partial block. One word is taken per clock, except that a CRC word waits in
// the input register while a previous result is held: each word passes an input register, the
// CRC and field logic, and a result register. The single-word CRC update sets the clock period.
module readout_block_crc_checker_core
   import rbcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] data_word
   input  logic                  req_tuser,   // [0] block_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [11:0] bunch_count, [19:12] event_count, [23:20] status_flags, [35:24] chip_id,
   // [51:36] received_crc, [67:52] computed_crc, [68] crc_match, [69] header_ok, [71:70] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic              in_start_ff;

   logic [WORD_W-1:0] crc_ff, crc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [POS_W-1:0]  pos_eff;
   logic [WORD_W-1:0] crc_base, crc_next;
   logic              is_last, fire, accept;

   always_comb begin
      if (in_start_ff || (pos_ff > LAST_POS)) begin
         pos_eff  = POS_FIRST;
         crc_base = CRC_INIT;
      end else begin
         pos_eff  = pos_ff;
         crc_base = crc_ff;
      end
   end

   assign is_last    = (pos_eff == LAST_POS);
   // a word that yields no result never waits on the output side
   assign fire       = in_valid_ff && (!is_last || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   rbcc_crc_fold u_fold (
      .crc_in  (crc_base),
      .word_in (in_word_ff),
      .crc_out (crc_next)
   );

   always_comb begin
      in_valid_in  = accept || (in_valid_ff && !fire);
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      w3_in        = w3_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (fire) begin
         if (!is_last) begin
            crc_in = crc_next;
            pos_in = POS_W'(pos_eff + 1'b1);
            if (pos_eff == POS_FIRST)  w1_in = in_word_ff;
            if (pos_eff == POS_SECOND) w2_in = in_word_ff;
            if (pos_eff == POS_THIRD)  w3_in = in_word_ff;
         end else begin
            crc_in               = CRC_INIT;
            pos_in               = POS_FIRST;
            rsp_valid_in         = 1'b1;
            rsp_in.bunch_count   = w1_ff[11:0];
            rsp_in.event_count   = w2_ff[11:4];
            rsp_in.status_flags  = w2_ff[3:0];
            rsp_in.chip_id       = w3_ff[11:0];
            rsp_in.received_crc  = in_word_ff;
            rsp_in.computed_crc  = crc_base;
            rsp_in.crc_match     = (crc_base == in_word_ff);
            rsp_in.header_ok     = (w1_ff[15:12] == HDR_NIB_FIRST)
                                && (w2_ff[15:12] == HDR_NIB_SECOND)
                                && (w3_ff[15:12] == HDR_NIB_THIRD);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= CRC_INIT;
         pos_ff       <= POS_FIRST;
         w1_ff        <= '0;
         w2_ff        <= '0;
         w3_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         pos_ff       <= pos_in;
         w1_ff        <= w1_in;
         w2_ff        <= w2_in;
         w3_ff        <= w3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff  <= req_tdata;
         in_start_ff <= req_tuser;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};

endmodule

>>> test/testbench.sv
// Testbench: readout block CRC checker core, streamed blocks against a cycle-free predictor.
`timescale 1ns / 1ps
module testbench
   import rbcc_pkg::*;
();

   typedef struct packed {
      logic [15:0] word;
      logic        start;
   } block_word_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;   // [15:0] data_word
   logic                  req_tuser  = 1'b0; // [0] block_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [11:0] bunch_count, [19:12] event_count, [23:20] status_flags, [35:24] chip_id,
   // [51:36] received_crc, [67:52] computed_crc, [68] crc_match, [69] header_ok, [71:70] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   readout_block_crc_checker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   block_word_type word_q[$];
   rsp_type        expected_rsp_q[$];
   block_word_type next_word;
   rsp_type        exp_rsp;
   rsp_type        got_rsp;

   // predictor state
   logic [15:0]      crc_acc  = CRC_INIT;
   logic [POS_W-1:0] word_pos = POS_FIRST;
   logic [15:0]      bc_word  = '0;
   logic [15:0]      ec_word  = '0;
   logic [15:0]      id_word  = '0;

   logic req_taken   = 1'b0;
   int   cycle_count = 0;
   int   error_count = 0;
   int   words_sent  = 0;
   int   rsp_checked = 0;
   int   crc_good_seen = 0;
   int   crc_bad_seen  = 0;
   int   hdr_bad_seen  = 0;
   logic quiet;

   // long stretch with no idling on either side
   assign quiet = (cycle_count >= 300) && (cycle_count < 700);

   function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [15:0] w);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 16; i++) begin
         if (c[0] ^ w[i]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic logic [11:0] pick12();
      case ($urandom_range(7))
         0: return 12'h000;
         1: return 12'hFFF;
         default: return 12'($urandom);
      endcase
   endfunction

   task automatic push_word(input logic [15:0] w, input logic s);
      block_word_type item;
      item.word  = w;
      item.start = s;
      word_q.push_back(item);
   endtask

   task automatic predict_word(input logic [15:0] w, input logic s);
      rsp_type r;
      if (s || word_pos > LAST_POS) begin
         word_pos = POS_FIRST;
         crc_acc  = CRC_INIT;
      end
      if (word_pos < LAST_POS) begin
         case (word_pos)
            POS_FIRST:  bc_word = w;
            POS_SECOND: ec_word = w;
            POS_THIRD:  id_word = w;
            default: ;
         endcase
         crc_acc  = crc16_fold(crc_acc, w);
         word_pos = word_pos + 1'b1;
      end else begin
         r.bunch_count  = bc_word[11:0];
         r.event_count  = ec_word[11:4];
         r.status_flags = ec_word[3:0];
         r.chip_id      = id_word[11:0];
         r.received_crc = w;
         r.computed_crc = crc_acc;
         r.crc_match    = (crc_acc == w);
         r.header_ok    = (bc_word[15:12] == HDR_NIB_FIRST) &&
                          (ec_word[15:12] == HDR_NIB_SECOND) &&
                          (id_word[15:12] == HDR_NIB_THIRD);
         expected_rsp_q.push_back(r);
         crc_acc  = CRC_INIT;
         word_pos = POS_FIRST;
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         error_count++;
      end
   endtask

   // driver: new word offered at the falling edge once the previous one has gone
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (word_q.size() != 0 && (quiet || $urandom_range(99) >= 29)) begin
            next_word = word_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_word.word;
            req_tuser  <= next_word.start;
            words_sent++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= quiet || ($urandom_range(99) >= 29);
   end

   // monitor: results checked first, then the accepted word goes to the predictor
   always @(posedge clock) begin
      cycle_count++;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp_q.size() == 0) begin
            $error("unexpected result word %0h", rsp_tdata);
            error_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            got_rsp = rsp_type'(rsp_tdata[69:0]);
            check_field("bunch_count", 16'(exp_rsp.bunch_count), 16'(got_rsp.bunch_count));
            check_field("event_count", 16'(exp_rsp.event_count), 16'(got_rsp.event_count));
            check_field("status_flags", 16'(exp_rsp.status_flags),
                        16'(got_rsp.status_flags));
            check_field("chip_id", 16'(exp_rsp.chip_id), 16'(got_rsp.chip_id));
            check_field("received_crc", exp_rsp.received_crc, got_rsp.received_crc);
            check_field("computed_crc", exp_rsp.computed_crc, got_rsp.computed_crc);
            check_field("crc_match", 16'(exp_rsp.crc_match), 16'(got_rsp.crc_match));
            check_field("header_ok", 16'(exp_rsp.header_ok), 16'(got_rsp.header_ok));
            check_field("pad", 16'h0, 16'(rsp_tdata[71:70]));
            rsp_checked++;
            if (exp_rsp.crc_match) crc_good_seen++;
            else crc_bad_seen++;
            if (!exp_rsp.header_ok) hdr_bad_seen++;
         end
      end
      if (!reset && req_tvalid && req_tready) predict_word(req_tdata, req_tuser);
   end

   initial begin
      logic [15:0] blk [12];
      logic [15:0] c;
      int          kind;
      int          n;
      int          total_words;

      // full-scale header fields, correct CRC
      blk[0] = 16'hAFFF;
      blk[1] = 16'hCFFF;
      blk[2] = 16'hEFFF;
      for (int i = 3; i < 11; i++) blk[i] = 16'hFFFF;
      c = CRC_INIT;
      for (int i = 0; i < 11; i++) c = crc16_fold(c, blk[i]);
      blk[11] = c;
      for (int i = 0; i < 12; i++) push_word(blk[i], i == 0);
      // back to back without start, then start flag lands on the CRC slot
      for (int i = 0; i < 11; i++) push_word(16'h0000, 1'b0);
      push_word(16'hFFFF, 1'b1);
      total_words = 24;

      while (total_words < 624) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            if ($urandom_range(99) < 80) begin
               blk[0] = {HDR_NIB_FIRST, pick12()};
               blk[1] = {HDR_NIB_SECOND, pick12()};
               blk[2] = {HDR_NIB_THIRD, pick12()};
            end else begin
               blk[0] = {4'($urandom), pick12()};
               blk[1] = {4'($urandom), pick12()};
               blk[2] = {4'($urandom), pick12()};
            end
            for (int i = 3; i < 11; i++) blk[i] = 16'($urandom);
            c = CRC_INIT;
            for (int i = 0; i < 11; i++) c = crc16_fold(c, blk[i]);
            if ($urandom_range(99) < 30) blk[11] = c ^ (16'h1 << $urandom_range(15));
            else blk[11] = c;
            n = $urandom_range(1);
            for (int i = 0; i < 12; i++) push_word(blk[i], (i == 0) && n == 1);
            total_words += 12;
         end else if (kind < 80) begin
            // truncated block, dropped by the next start unless later words complete it
            n = $urandom_range(1, 11);
            for (int i = 0; i < n; i++) push_word(16'($urandom), i == 0);
            total_words += n;
         end else begin
            n = $urandom_range(1, 15);
            for (int i = 0; i < n; i++) push_word(16'($urandom), $urandom_range(9) == 0);
            total_words += n;
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      @(posedge clock);
      while (word_q.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d words sent, %0d result words checked", words_sent, rsp_checked);
      $display("CRC good %0d, CRC bad %0d, header bad %0d", crc_good_seen, crc_bad_seen,
               hdr_bad_seen);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("timeout with %0d results outstanding", expected_rsp_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> files.f
sv/rbcc_pkg.sv
sv/rbcc_crc_fold.sv
sv/readout_block_crc_checker_core.sv
test/testbench.sv
